>>> src/evad_pkg.sv
// Shared types, register codes and constants for the energy voice activity detector.
// Used by the top level and evad_div; depends on nothing.
package evad_pkg;

	localparam int MAX_FRAME = 1024;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int ENERGY_W  = 30 + CNT_W;
	localparam int DIV_W     = ENERGY_W + 20;
	localparam int X_W       = DIV_W + 1;
	localparam int E_W       = $clog2(X_W);

	localparam logic [7:0] REG_THRESHOLD = 8'd0;
	localparam logic [7:0] REG_MIN_LEVEL = 8'd1;
	localparam logic [7:0] REG_CAL_COUNT = 8'd2;
	localparam logic [7:0] REG_SMOOTHING = 8'd3;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_ACC, ST_DIV1, ST_DIV1W, ST_NORM, ST_LSQ, ST_LCHK,
		ST_LMUL, ST_LRND, ST_DEC, ST_FUP1, ST_FUP2, ST_FUP3, ST_SIG1, ST_SIG2,
		ST_PWM, ST_PWR, ST_DIV2, ST_DIV2W, ST_PSC1, ST_PSC2, ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [31:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r, v, b;
		r = '0;
		v = x;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^(k-16)) in Q30, chained roots as the fraction builder needs them
	function automatic logic [31:0] pow2_root(input int k);
		logic [63:0] c;
		c = isqrt64(64'h2000_0000_0000_0000);
		for (int j = 15; j > k; j--)
			c = isqrt64(c << 30);
		return c[31:0];
	endfunction

	localparam logic [31:0] ROOT_TAB [0:15] = '{
		pow2_root(0), pow2_root(1), pow2_root(2), pow2_root(3),
		pow2_root(4), pow2_root(5), pow2_root(6), pow2_root(7),
		pow2_root(8), pow2_root(9), pow2_root(10), pow2_root(11),
		pow2_root(12), pow2_root(13), pow2_root(14), pow2_root(15)
	};

endpackage

>>> src/energy_voice_activity_detector.sv
// Energy voice activity detector: squares and sums samples over a frame and, on the
// last beat, reports level, noise floor, SNR, decision and probability in one beat.
// Each sample is squared on the shared multiplier, then accumulated. A frame end adds a
// bit-serial division, normalizing shifts and log2 squaring and, once calibration is
// over, a second bit-serial division, preceded by the 2^-u product chain when the
// fraction of u is not zero, plus any output stall. Input is held off while a frame
// end is being worked on.
// Depends on evad_pkg, evad_mul and evad_div.
module energy_voice_activity_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [15:0] probability, [32:16] level_dbfs,
	                               // [49:33] noise_floor_dbfs, [66:50] snr_db, rest 0
	output logic [1:0]  m_tuser,   // [0] voice_active, [1] frame_overflow
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import evad_pkg::*;

	state_t state_q, state_d;

	logic signed [15:0] thr_q;
	logic signed [16:0] minl_q;
	logic [7:0]         cal_q;
	logic [15:0]        alpha_q;

	logic [ENERGY_W-1:0] energy_q;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic signed [16:0]  floor_q;
	logic [7:0]          fcal_q;

	logic signed [15:0] sample_q;
	logic               fend_q;
	logic [X_W-1:0]     x_q;
	logic [E_W-1:0]     e_q;
	logic [30:0]        m_q;
	logic [15:0]        frac_q;
	logic [3:0]         k_q;
	logic signed [16:0] level_q;
	logic signed [17:0] snr_q;
	logic signed [18:0] d_q;
	logic               active_q;
	logic               below_q;
	logic signed [35:0] acc_q;
	logic [4:0]         ui_q;
	logic               ufz_q;
	logic [15:0]        f_q;
	logic [31:0]        r_q;
	logic [16:0]        prob_q;

	logic [71:0] out_data_q;
	logic [1:0]  out_user_q;
	logic        out_valid_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	div_req_t           dreq;
	div_rsp_t           drsp;

	logic               in_acc;
	logic               out_free;
	logic [31:0]        lsq_t;
	logic signed [7:0]  e_rel;
	logic signed [23:0] rel;
	logic signed [41:0] lv;
	logic signed [17:0] snr_c;
	logic signed [35:0] fsum;
	logic signed [19:0] fl_c;
	logic [18:0]        ad;
	logic [25:0]        u_raw;
	logic [20:0]        u_cap;
	logic [31:0]        g;
	logic [31:0]        den;
	logic [47:0]        num;
	logic [16:0]        pscaled;

	evad_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));
	evad_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	// datapath helpers
	assign lsq_t = prod[61:30];
	assign e_rel = 8'($signed({1'b0, e_q})) - 8'sd50;
	assign rel   = {e_rel, frac_q};
	assign lv    = 42'((prod + 66'sd8388608) >>> 24);
	assign snr_c = 18'(level_q) - 18'(floor_q);
	assign fsum  = acc_q + prod[35:0];
	assign fl_c  = 20'((fsum + 36'sd32768) >>> 16);
	assign ad    = d_q[18] ? 19'(-d_q) : 19'(d_q);
	assign u_raw = 26'((prod[33:0] + 34'd128) >> 8);
	assign u_cap = (u_raw > 26'd1310720) ? 21'd1310720 : u_raw[20:0];
	assign g     = r_q >> ({1'b0, ui_q} + {5'd0, !ufz_q});
	assign den   = 32'h4000_0000 + g;
	assign num   = (d_q[18] || d_q == '0) ? ({g, 16'd0} + {17'd0, den[31:1]})
	                                       : (48'h4000_0000_0000 + {17'd0, den[31:1]});
	assign pscaled = prod[32:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		mul_a         = '0;
		mul_b         = '0;
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (count_q < CNT_W'(MAX_FRAME))
						state_d = ST_SQ;
					else if (s_tlast)
						state_d = ST_DIV1;
				end
			end
			ST_SQ: begin
				mul_a   = 33'(sample_q);
				mul_b   = 33'(sample_q);
				state_d = ST_ACC;
			end
			ST_ACC: state_d = fend_q ? ST_DIV1 : ST_IDLE;
			ST_DIV1: begin
				dreq.start    = 1'b1;
				dreq.dividend = {energy_q, 20'd0};
				dreq.divisor  = (count_q == '0) ? 32'd1 : 32'(count_q);
				state_d       = ST_DIV1W;
			end
			ST_DIV1W: if (drsp.done) state_d = ST_NORM;
			ST_NORM: if (x_q[X_W-1]) state_d = ST_LSQ;
			ST_LSQ: begin
				mul_a   = 33'({2'b0, m_q});
				mul_b   = 33'({2'b0, m_q});
				state_d = ST_LCHK;
			end
			ST_LCHK: state_d = (k_q == '0) ? ST_LMUL : ST_LSQ;
			ST_LMUL: begin
				mul_a   = 33'(rel);
				mul_b   = 33'sd197283;
				state_d = ST_LRND;
			end
			ST_LRND: state_d = ST_DEC;
			ST_DEC: begin
				if (fcal_q < cal_q)
					state_d = ST_OUT;
				else if (level_q >= minl_q && snr_c >= 18'(thr_q))
					state_d = ST_SIG1;
				else
					state_d = ST_FUP1;
			end
			ST_FUP1: begin
				mul_a   = 33'({1'b0, alpha_q});
				mul_b   = 33'(floor_q);
				state_d = ST_FUP2;
			end
			ST_FUP2: begin
				mul_a   = 33'(17'h10000 - {1'b0, alpha_q});
				mul_b   = 33'(level_q);
				state_d = ST_FUP3;
			end
			ST_FUP3: state_d = ST_SIG1;
			ST_SIG1: begin
				mul_a   = 33'({1'b0, ad});
				mul_b   = 33'sd31516;
				state_d = ST_SIG2;
			end
			ST_SIG2: state_d = (u_cap[15:0] == '0) ? ST_DIV2 : ST_PWM;
			ST_PWM: begin
				mul_a   = 33'({1'b0, r_q});
				mul_b   = f_q[k_q] ? 33'({1'b0, ROOT_TAB[k_q]}) : 33'sh4000_0000;
				state_d = ST_PWR;
			end
			ST_PWR: state_d = (k_q == '0) ? ST_DIV2 : ST_PWM;
			ST_DIV2: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'(num);
				dreq.divisor  = den;
				state_d       = ST_DIV2W;
			end
			ST_DIV2W: if (drsp.done) state_d = below_q ? ST_PSC1 : ST_OUT;
			ST_PSC1: begin
				mul_a   = 33'({16'd0, prob_q});
				mul_b   = 33'sd26214;
				state_d = ST_PSC2;
			end
			ST_PSC2: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= 16'sd1536;
			minl_q      <= -17'sd12800;
			cal_q       <= 8'd10;
			alpha_q     <= 16'd62259;
			energy_q    <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			floor_q     <= '0;
			fcal_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_THRESHOLD: thr_q   <= cfg_data[15:0];
					REG_MIN_LEVEL: minl_q  <= cfg_data;
					REG_CAL_COUNT: cal_q   <= cfg_data[7:0];
					REG_SMOOTHING: alpha_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			// a new beat loaded in ST_OUT takes the place of the one leaving
			if (out_valid_q && m_tready && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc && !(count_q < CNT_W'(MAX_FRAME))) ovf_q <= 1'b1;
				ST_ACC: begin
					energy_q <= energy_q + ENERGY_W'(prod[30:0]);
					count_q  <= count_q + 1'b1;
				end
				ST_DEC: begin
					if (fcal_q < cal_q) begin
						if (fcal_q == '0 || level_q > floor_q)
							floor_q <= level_q;
						fcal_q <= fcal_q + 1'b1;
					end
				end
				ST_FUP3: floor_q <= fl_c[16:0];
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						energy_q    <= '0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sample_q <= s_tdata;
					fend_q   <= s_tlast;
				end
			end
			ST_DIV1W: begin
				x_q <= X_W'(drsp.quotient) + X_W'(1126);
				e_q <= E_W'(X_W - 1);
			end
			ST_NORM: begin
				if (x_q[X_W-1]) begin
					m_q    <= x_q[X_W-1 -: 31];
					frac_q <= '0;
					k_q    <= 4'd15;
				end else begin
					x_q <= {x_q[X_W-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			ST_LCHK: begin
				if (lsq_t[31]) begin
					m_q         <= lsq_t[31:1];
					frac_q[k_q] <= 1'b1;
				end else begin
					m_q <= lsq_t[30:0];
				end
				k_q <= k_q - 1'b1;
			end
			ST_LRND: begin
				if (lv < -42'sd46080)
					level_q <= -17'sd46080;
				else if (lv > 42'sd2048)
					level_q <= 17'sd2048;
				else
					level_q <= lv[16:0];
			end
			ST_DEC: begin
				snr_q    <= (fcal_q < cal_q) ? 18'sd0 : snr_c;
				d_q      <= 19'(snr_c) - 19'(thr_q);
				active_q <= (fcal_q >= cal_q) && level_q >= minl_q && snr_c >= 18'(thr_q);
				below_q  <= level_q < minl_q;
				prob_q   <= '0;
			end
			ST_FUP2: acc_q <= prod[35:0];
			ST_SIG2: begin
				ui_q  <= u_cap[20:16];
				ufz_q <= (u_cap[15:0] == '0);
				f_q   <= 16'(17'h10000 - {1'b0, u_cap[15:0]});
				r_q   <= 32'h4000_0000;
				k_q   <= 4'd15;
			end
			ST_PWR: begin
				r_q <= prod[61:30];
				k_q <= k_q - 1'b1;
			end
			ST_DIV2W: if (drsp.done) prob_q <= drsp.quotient[16:0];
			ST_PSC2: prob_q <= pscaled;
			ST_OUT: begin
				if (out_free) begin
					out_data_q <= {5'd0, snr_q[16:0], floor_q, level_q,
					               prob_q[16] ? 16'hFFFF : prob_q[15:0]};
					out_user_q <= {ovf_q, active_q};
				end
			end
			default: ;
		endcase
	end
endmodule

>>> src/evad_mul.sv
// Shared signed multiplier with registered product.
// Depends on nothing; operands are set by the sequencer in the top level.
module evad_mul (
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] prod
);
	logic signed [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;
endmodule

>>> src/evad_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on evad_pkg for widths and the request/response structs.
module evad_div (
	input  logic               clk,
	input  logic               arst_n,
	input  evad_pkg::div_req_t req,
	output evad_pkg::div_rsp_t rsp
);
	import evad_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic [DIV_W-1:0] dvd_q;
	logic [31:0]      dsr_q;
	logic [32:0]      rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      rem_sh;
	logic             qbit;

	assign rem_sh = {rem_q[31:0], dvd_q[DIV_W-1]};
	assign qbit   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;
endmodule
